// ===== design/lsil_pkg.sv =====
// ----------------------------------------------------------------------------
// Line start index lookup package
// Shared widths, limits, item types and codes for the line start lookup block.
// ----------------------------------------------------------------------------
package lsil_pkg;

	localparam int MAX_LINES  = 1024;
	localparam int MAX_BYTES  = 1048576;
	localparam int IDX_W      = $clog2(MAX_LINES);
	localparam int LINE_W     = 11;
	localparam int OFF_W      = 21;
	localparam int CMD_DEPTH  = 4;
	localparam int CPTR_W     = $clog2(CMD_DEPTH);
	localparam int CCNT_W     = $clog2(CMD_DEPTH + 1);

	localparam logic [7:0] NEWLINE_BYTE = 8'd10;

	typedef enum logic [1:0] {
		OP_CLEAR  = 2'd0,
		OP_APPEND = 2'd1,
		OP_FIND   = 2'd2,
		OP_LOCATE = 2'd3
	} opcode_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_RANGE = 2'd1,
		ST_FULL  = 2'd2
	} status_t;

	typedef struct packed {
		logic [1:0]        opcode;
		logic [7:0]        data_byte;
		logic [OFF_W-1:0]  query_offset;
		logic [LINE_W-1:0] query_line;
		logic [OFF_W-1:0]  query_column;
	} item_t;

	typedef struct packed {
		status_t           status;
		logic [LINE_W-1:0] line_out;
		logic [OFF_W-1:0]  column_out;
		logic [OFF_W-1:0]  offset_out;
	} result_t;

	// Classified command passed from the front to the back.
	typedef struct packed {
		opcode_t           kind;
		logic              is_newline;
		logic              line_zero;
		logic [LINE_W-1:0] query_line;
		logic [LINE_W-1:0] line_idx;
		logic [OFF_W-1:0]  query_offset;
		logic [OFF_W-1:0]  query_column;
	} cmd_t;

	typedef struct packed {
		logic              busy;
		logic [LINE_W-1:0] line_count;
	} back_stat_t;

endpackage

// ===== design/lsil_front.sv =====
// ----------------------------------------------------------------------------
// Line start lookup front end
// Accepts input beats, classifies them and hands them to the command queue.
// ----------------------------------------------------------------------------
module lsil_front (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	output logic           full,
	input  lsil_pkg::item_t item,
	output logic           cmd_valid,
	input  logic           cmd_ready,
	output lsil_pkg::cmd_t cmd
);

	logic           valid_s1;
	lsil_pkg::cmd_t cmd_s1;
	lsil_pkg::cmd_t cmd_new;
	logic           take;

	always_comb begin
		cmd_new.kind         = lsil_pkg::opcode_t'(item.opcode);
		cmd_new.is_newline   = (item.data_byte == lsil_pkg::NEWLINE_BYTE);
		cmd_new.line_zero    = (item.query_line == '0);
		cmd_new.query_line   = item.query_line;
		cmd_new.line_idx     = item.query_line - lsil_pkg::LINE_W'(1);
		cmd_new.query_offset = item.query_offset;
		cmd_new.query_column = item.query_column;
	end

	assign full      = valid_s1 && !cmd_ready;
	assign take      = push && !full;
	assign cmd_valid = valid_s1;
	assign cmd       = cmd_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take) begin
			valid_s1 <= 1'b1;
		end else if (cmd_ready) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			cmd_s1 <= cmd_new;
		end
	end

endmodule

// ===== design/lsil_cmd_fifo.sv =====
// ----------------------------------------------------------------------------
// Line start lookup command queue
// Short queue of classified commands between the front and the back.
// ----------------------------------------------------------------------------
module lsil_cmd_fifo (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           wr_valid,
	output logic           wr_ready,
	input  lsil_pkg::cmd_t wr_cmd,
	output logic           rd_valid,
	input  logic           rd_ready,
	output lsil_pkg::cmd_t rd_cmd
);

	lsil_pkg::cmd_t                    slots_q [lsil_pkg::CMD_DEPTH];
	logic [lsil_pkg::CPTR_W-1:0]       wr_ptr_q;
	logic [lsil_pkg::CPTR_W-1:0]       rd_ptr_q;
	logic [lsil_pkg::CCNT_W-1:0]       count_q;
	logic                              do_wr;
	logic                              do_rd;

	assign wr_ready = (count_q != lsil_pkg::CCNT_W'(lsil_pkg::CMD_DEPTH));
	assign rd_valid = (count_q != '0);
	assign rd_cmd   = slots_q[rd_ptr_q];
	assign do_wr    = wr_valid && wr_ready;
	assign do_rd    = rd_valid && rd_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= wr_ptr_q + lsil_pkg::CPTR_W'(1);
			end
			if (do_rd) begin
				rd_ptr_q <= rd_ptr_q + lsil_pkg::CPTR_W'(1);
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + lsil_pkg::CCNT_W'(1);
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - lsil_pkg::CCNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_wr) begin
			slots_q[wr_ptr_q] <= wr_cmd;
		end
	end

endmodule

// ===== design/lsil_back.sv =====
// ----------------------------------------------------------------------------
// Line start lookup back end
// Holds the line start table and counters, executes one command at a time
// and keeps the result register.
// ----------------------------------------------------------------------------
module lsil_back (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cmd_valid,
	output logic                 cmd_ready,
	input  lsil_pkg::cmd_t       cmd,
	output logic                 res_valid,
	input  logic                 res_pop,
	output lsil_pkg::result_t    res,
	output lsil_pkg::back_stat_t stat
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_SEARCH,
		S_FIND_DONE,
		S_LOC_A,
		S_LOC_B
	} state_t;

	localparam int LW = lsil_pkg::LINE_W;
	localparam int OW = lsil_pkg::OFF_W;
	localparam int IW = lsil_pkg::IDX_W;

	// Line start table; entry zero is never written and reads as zero.
	logic [OW-1:0] table_q [lsil_pkg::MAX_LINES];
	logic [OW-1:0] rd_data_q;
	logic          rd_zero_q;
	logic [IW-1:0] rd_addr;
	logic          wr_en;
	logic [IW-1:0] wr_addr;
	logic [OW-1:0] wr_data;

	state_t            state_q, state_d;
	lsil_pkg::cmd_t    cmd_q, cmd_d;
	logic [LW-1:0]     lo_q, lo_d, hi_q, hi_d, mid_q, mid_d;
	logic [OW-1:0]     best_q, best_d;
	logic [OW:0]       off_q, off_d;
	logic [LW-1:0]     line_cnt_q, line_cnt_d;
	logic [OW-1:0]     byte_cnt_q, byte_cnt_d;
	logic              res_valid_q, res_valid_d;
	lsil_pkg::result_t res_q, res_d;

	logic          take;
	logic          freed;
	logic [OW-1:0] start_val;
	logic          le;
	logic [LW-1:0] lo_n, hi_n;
	logic [LW:0]   mid_sum;
	logic [LW-1:0] next_idx;
	logic [OW:0]   limit;
	logic [OW-1:0] byte_inc;

	assign freed     = !res_valid_q || res_pop;
	assign cmd_ready = (state_q == S_IDLE) && freed;
	assign take      = cmd_valid && cmd_ready;
	assign start_val = rd_zero_q ? '0 : rd_data_q;
	assign byte_inc  = byte_cnt_q + OW'(1);
	assign next_idx  = cmd_q.line_idx + LW'(1);

	always_comb begin
		state_d     = state_q;
		cmd_d       = cmd_q;
		lo_d        = lo_q;
		hi_d        = hi_q;
		mid_d       = mid_q;
		best_d      = best_q;
		off_d       = off_q;
		line_cnt_d  = line_cnt_q;
		byte_cnt_d  = byte_cnt_q;
		res_valid_d = res_valid_q && !res_pop;
		res_d       = res_q;
		rd_addr     = mid_q[IW-1:0];
		wr_en       = 1'b0;
		wr_addr     = line_cnt_q[IW-1:0];
		wr_data     = byte_inc;
		le          = 1'b0;
		lo_n        = lo_q;
		hi_n        = hi_q;
		mid_sum     = '0;
		limit       = '0;

		case (state_q)
			S_IDLE: begin
				if (take) begin
					cmd_d             = cmd;
					res_d.status      = lsil_pkg::ST_OK;
					res_d.line_out    = '0;
					res_d.column_out  = '0;
					res_d.offset_out  = '0;
					case (cmd.kind)
						lsil_pkg::OP_CLEAR: begin
							line_cnt_d  = LW'(1);
							byte_cnt_d  = '0;
							res_valid_d = 1'b1;
						end
						lsil_pkg::OP_APPEND: begin
							res_valid_d = 1'b1;
							if (byte_cnt_q >= OW'(lsil_pkg::MAX_BYTES)) begin
								res_d.status = lsil_pkg::ST_FULL;
							end else if (cmd.is_newline &&
									line_cnt_q >= LW'(lsil_pkg::MAX_LINES)) begin
								res_d.status = lsil_pkg::ST_FULL;
							end else begin
								byte_cnt_d = byte_inc;
								if (cmd.is_newline) begin
									wr_en      = 1'b1;
									line_cnt_d = line_cnt_q + LW'(1);
								end
							end
						end
						lsil_pkg::OP_FIND: begin
							if (cmd.query_offset > byte_cnt_q) begin
								res_d.status = lsil_pkg::ST_RANGE;
								res_valid_d  = 1'b1;
							end else begin
								// Upper-bound search over [0, line_count).
								lo_d    = '0;
								hi_d    = line_cnt_q;
								mid_d   = line_cnt_q >> 1;
								best_d  = '0;
								rd_addr = mid_d[IW-1:0];
								state_d = S_SEARCH;
							end
						end
						lsil_pkg::OP_LOCATE: begin
							if (cmd.line_zero || cmd.query_line > line_cnt_q) begin
								res_d.status = lsil_pkg::ST_RANGE;
								res_valid_d  = 1'b1;
							end else begin
								rd_addr = cmd.line_idx[IW-1:0];
								state_d = S_LOC_A;
							end
						end
						default: begin
							res_valid_d = 1'b1;
						end
					endcase
				end
			end
			S_SEARCH: begin
				le = (start_val <= cmd_q.query_offset);
				if (le) begin
					lo_n   = mid_q + LW'(1);
					best_d = start_val;
				end else begin
					hi_n = mid_q;
				end
				lo_d = lo_n;
				hi_d = hi_n;
				if (lo_n < hi_n) begin
					mid_sum = {1'b0, lo_n} + {1'b0, hi_n};
					mid_d   = mid_sum[LW:1];
					rd_addr = mid_d[IW-1:0];
				end else begin
					state_d = S_FIND_DONE;
				end
			end
			S_FIND_DONE: begin
				res_d.status     = lsil_pkg::ST_OK;
				res_d.line_out   = lo_q;
				res_d.column_out = cmd_q.query_offset - best_q;
				res_d.offset_out = '0;
				res_valid_d      = 1'b1;
				state_d          = S_IDLE;
			end
			S_LOC_A: begin
				off_d   = {1'b0, start_val} + {1'b0, cmd_q.query_column};
				rd_addr = next_idx[IW-1:0];
				state_d = S_LOC_B;
			end
			S_LOC_B: begin
				// The next line start bounds the column, or the text end on the last line.
				if (next_idx < line_cnt_q) begin
					limit = {1'b0, start_val};
				end else begin
					limit = {1'b0, byte_cnt_q} + (OW + 1)'(1);
				end
				res_d.line_out   = '0;
				res_d.column_out = '0;
				if (off_q >= limit || off_q > {1'b0, byte_cnt_q}) begin
					res_d.status     = lsil_pkg::ST_RANGE;
					res_d.offset_out = '0;
				end else begin
					res_d.status     = lsil_pkg::ST_OK;
					res_d.offset_out = off_q[OW-1:0];
				end
				res_valid_d = 1'b1;
				state_d     = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			line_cnt_q  <= LW'(1);
			byte_cnt_q  <= '0;
			res_valid_q <= 1'b0;
			lo_q        <= '0;
			hi_q        <= '0;
			mid_q       <= '0;
			best_q      <= '0;
			off_q       <= '0;
			cmd_q       <= '0;
			res_q       <= '0;
		end else begin
			state_q     <= state_d;
			line_cnt_q  <= line_cnt_d;
			byte_cnt_q  <= byte_cnt_d;
			res_valid_q <= res_valid_d;
			lo_q        <= lo_d;
			hi_q        <= hi_d;
			mid_q       <= mid_d;
			best_q      <= best_d;
			off_q       <= off_d;
			cmd_q       <= cmd_d;
			res_q       <= res_d;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			table_q[wr_addr] <= wr_data;
		end
		rd_data_q <= table_q[rd_addr];
		rd_zero_q <= (rd_addr == '0);
	end

	assign res_valid       = res_valid_q;
	assign res             = res_q;
	assign stat.busy       = (state_q != S_IDLE);
	assign stat.line_count = line_cnt_q;

endmodule

// ===== design/line_start_index_lookup_top.sv =====
// ----------------------------------------------------------------------------
// Line start index lookup
// Text line table with offset-to-line/column and line/column-to-offset lookup.
// ----------------------------------------------------------------------------
// Usage:
// Input beats are written like a queue: item is taken when push is high and
// full is low. Each beat is clear, append byte, offset query or line/column
// query, and each produces exactly one result beat.
// Results are read like a queue: while empty is low the oldest result sits on
// result, and pop with empty low takes it.
// Path: the front stage register, then the command queue, then the back end:
// clear and append finish from the idle state, a line/column query passes
// through S_LOC_A and S_LOC_B, and an offset query does one table read per
// binary search step and then S_FIND_DONE.
// The back end runs one command at a time; up to five commands wait ahead of
// it, so push keeps being taken while a result waits in the output register.
// When pop is held low the result register holds, the back end stops after
// one result and the queue then fills until full rises.
// Reset empties the text: one line starting at offset 0, no bytes, no result.
// ----------------------------------------------------------------------------
module line_start_index_lookup_top (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	output logic              full,
	input  lsil_pkg::item_t   item,
	output logic              empty,
	input  logic              pop,
	output lsil_pkg::result_t result
);

	logic                 f_valid;
	logic                 f_ready;
	lsil_pkg::cmd_t       f_cmd;
	logic                 q_valid;
	logic                 q_ready;
	lsil_pkg::cmd_t       q_cmd;
	logic                 res_valid;
	lsil_pkg::back_stat_t stat;

	lsil_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.item      (item),
		.cmd_valid (f_valid),
		.cmd_ready (f_ready),
		.cmd       (f_cmd)
	);

	lsil_cmd_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_valid (f_valid),
		.wr_ready (f_ready),
		.wr_cmd   (f_cmd),
		.rd_valid (q_valid),
		.rd_ready (q_ready),
		.rd_cmd   (q_cmd)
	);

	lsil_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (q_valid),
		.cmd_ready (q_ready),
		.cmd       (q_cmd),
		.res_valid (res_valid),
		.res_pop   (pop && res_valid),
		.res       (result),
		.stat      (stat)
	);

	assign empty = !res_valid;

`ifndef SYNTHESIS
	a_line_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		stat.line_count >= lsil_pkg::LINE_W'(1) &&
		stat.line_count <= lsil_pkg::LINE_W'(lsil_pkg::MAX_LINES))
		else $error("line count left its legal range");

	a_error_zero_fields: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && result.status != lsil_pkg::ST_OK) |->
		(result.line_out == '0 && result.column_out == '0 && result.offset_out == '0))
		else $error("non-ok result carries nonzero fields");

	a_found_line_exists: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && result.line_out != '0) |-> (result.line_out <= stat.line_count))
		else $error("offset query returned a line past the table");

	a_busy_holds_queue: assert property (@(posedge clk) disable iff (!arst_n)
		stat.busy |-> !q_ready)
		else $error("command taken while the back end is busy");
`endif

endmodule
